>>> hw/rtl/cds_pkg.sv
// Shared constants and types for the sparse-entry duplicate summer.
package cds_pkg;

   localparam int DEF_INDEX_WIDTH = 31;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int OUT_FIFO_DEPTH  = 4;

   // words pushed into the output queue in one cycle, in order
   typedef struct packed {
      logic push_first;
      logic push_second;
   } cds_push_type;

endpackage

>>> hw/rtl/cds_merge.sv
// Pending-entry register, key compare and saturating accumulate.
module cds_merge
   import cds_pkg::*;
#(
   parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   localparam int RES_WIDTH  = 2 * INDEX_WIDTH + VALUE_WIDTH + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [INDEX_WIDTH-1:0]        entry_row,
   input  logic [INDEX_WIDTH-1:0]        entry_col,
   input  logic signed [VALUE_WIDTH-1:0] entry_value,
   input  logic                          entry_last,
   output cds_push_type                  push,
   output logic [RES_WIDTH-1:0]          word_first,
   output logic [RES_WIDTH-1:0]          word_second
);

   localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic                          has_pending_ff, has_pending_in;
   logic [INDEX_WIDTH-1:0]        row_ff, row_in;
   logic [INDEX_WIDTH-1:0]        col_ff, col_in;
   logic signed [VALUE_WIDTH-1:0] sum_ff, sum_in;
   logic                          sat_ff, sat_in;

   logic                          match;
   logic [VALUE_WIDTH:0]          wide_sum;
   logic                          ovf;
   logic signed [VALUE_WIDTH-1:0] sat_sum;
   logic [INDEX_WIDTH-1:0]        nrow, ncol;
   logic signed [VALUE_WIDTH-1:0] nsum;
   logic                          nsat;
   logic                          emit_old;
   logic [RES_WIDTH-1:0]          old_word, new_word;

   assign match    = has_pending_ff && (entry_row == row_ff) && (entry_col == col_ff);
   assign wide_sum = {sum_ff[VALUE_WIDTH-1], sum_ff} + {entry_value[VALUE_WIDTH-1], entry_value};
   assign ovf      = wide_sum[VALUE_WIDTH] != wide_sum[VALUE_WIDTH-1];

   always_comb begin
      if (ovf) begin
         sat_sum = wide_sum[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
      end else begin
         sat_sum = wide_sum[VALUE_WIDTH-1:0];
      end
   end

   // entry as it stands after this word joins or replaces it
   always_comb begin
      if (match) begin
         nrow = row_ff;
         ncol = col_ff;
         nsum = sat_sum;
         nsat = sat_ff | ovf;
      end else begin
         nrow = entry_row;
         ncol = entry_col;
         nsum = entry_value;
         nsat = 1'b0;
      end
   end

   assign emit_old = has_pending_ff && !match;
   assign old_word = {row_ff, col_ff, sum_ff, sat_ff, 1'b0};
   assign new_word = {nrow, ncol, nsum, nsat, 1'b1};

   always_comb begin
      push.push_first  = fire && (emit_old || entry_last);
      push.push_second = fire && emit_old && entry_last;
      word_first       = emit_old ? old_word : new_word;
      word_second      = new_word;
   end

   always_comb begin
      has_pending_in = has_pending_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      sum_in         = sum_ff;
      sat_in         = sat_ff;
      if (fire) begin
         has_pending_in = !entry_last;
         row_in         = nrow;
         col_in         = ncol;
         sum_in         = nsum;
         sat_in         = nsat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_pending_ff <= 1'b0;
      end else begin
         has_pending_ff <= has_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      sum_ff <= sum_in;
      sat_ff <= sat_in;
   end

`ifndef ASSERT_OFF
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (fire && entry_last) |=> !has_pending_ff)
      else $error("pending entry survived a last word");

   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      (fire && !has_pending_ff) |-> !push.push_second)
      else $error("two results from an empty block");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.push_second |-> (!word_first[0] && word_second[0]))
      else $error("last flag misplaced on a pair of words");
`endif

endmodule

>>> hw/rtl/cds_out_fifo.sv
// Small result queue taking up to two words a cycle and giving one.
module cds_out_fifo
   import cds_pkg::*;
#(
   parameter int WIDTH = 2 * DEF_INDEX_WIDTH + DEF_VALUE_WIDTH + 2,
   parameter int DEPTH = OUT_FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  cds_push_type     push,
   input  logic [WIDTH-1:0] word_first,
   input  logic [WIDTH-1:0] word_second,
   output logic             room_two,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_word
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic             pop;
   logic [CNT_W-1:0] n_push;

   assign wr_next   = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign out_valid = count_ff != '0;
   assign out_word  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room_two  = count_ff <= CNT_W'(DEPTH - 2);
   assign n_push    = CNT_W'(push.push_first) + CNT_W'(push.push_second);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.push_second) begin
         wr_ptr_in = (wr_next == PTR_W'(DEPTH - 1)) ? '0 : wr_next + 1'b1;
      end else if (push.push_first) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + n_push - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_first) begin
         slot_ff[wr_ptr_ff] <= word_first;
      end
      if (push.push_second) begin
         slot_ff[wr_next] <= word_second;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue count beyond depth");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push_second |-> push.push_first)
      else $error("second word pushed without the first");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.push_first |-> count_ff <= CNT_W'(DEPTH - 2))
      else $error("push into a queue without room for two");
`endif

endmodule

>>> hw/rtl/coo_duplicate_summer.sv
// Top level: merges adjacent duplicate sparse entries with a saturating sum.
// Queueing: a merged word is written into the result queue at the edge that takes
//   the word closing it; if the queue was empty, rsp_ offers it in the next cycle.
// Throughput: one req_ word per cycle while req_ready is high; at most one rsp_ word per
//   cycle, so a stream of key changes ending in last or a low rsp_ready can hold off req_ready.
// req_ready depends only on the four-deep result queue having two free slots.
// Reset (synchronous) empties the pending entry and the result queue.
module coo_duplicate_summer
   import cds_pkg::*;
#(
   parameter int INDEX_WIDTH = DEF_INDEX_WIDTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [INDEX_WIDTH-1:0]        req_entry_row,
   input  logic [INDEX_WIDTH-1:0]        req_entry_col,
   input  logic signed [VALUE_WIDTH-1:0] req_entry_value,
   input  logic                          req_entry_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [INDEX_WIDTH-1:0]        rsp_out_row,
   output logic [INDEX_WIDTH-1:0]        rsp_out_col,
   output logic signed [VALUE_WIDTH-1:0] rsp_out_value,
   output logic                          rsp_out_saturated,
   output logic                          rsp_out_last
);

   localparam int RES_WIDTH = 2 * INDEX_WIDTH + VALUE_WIDTH + 2;

   cds_push_type         push;
   logic [RES_WIDTH-1:0] word_first, word_second, out_word;
   logic                 room_two;
   logic                 fire;

   assign req_ready = room_two;
   assign fire      = req_valid && room_two;

   cds_merge #(
      .INDEX_WIDTH (INDEX_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .entry_row   (req_entry_row),
      .entry_col   (req_entry_col),
      .entry_value (req_entry_value),
      .entry_last  (req_entry_last),
      .push        (push),
      .word_first  (word_first),
      .word_second (word_second)
   );

   cds_out_fifo #(
      .WIDTH (RES_WIDTH),
      .DEPTH (OUT_FIFO_DEPTH)
   ) u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .word_first  (word_first),
      .word_second (word_second),
      .room_two    (room_two),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_word    (out_word)
   );

   assign {rsp_out_row, rsp_out_col, rsp_out_value, rsp_out_saturated, rsp_out_last} = out_word;

endmodule
